[src/rtea_pkg.sv]
// rtea_pkg: constants and shared types of the reverb tail envelope adder.
// No dependencies; every other file takes what it needs by scoped names.
package rtea_pkg;

  // configuration register indexes
  localparam logic CFG_XOVER = 1'b0;
  localparam logic CFG_DECAY = 1'b1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int XOVER_W    = 17;
  localparam int DECAY_W    = 24;

  // envelope is Q1.24, so 1.0 needs 25 bits
  localparam int FRAC_W = 24;
  localparam int ENV_W  = 25;
  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << FRAC_W;

  // 0.3 in Q0.24
  localparam int GAIN_W = 23;
  localparam logic [GAIN_W-1:0] TAIL_GAIN = GAIN_W'(5033165);

  // half LSB for round half up after a shift by FRAC_W
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  // peak at or below this many LSB gets no tail
  localparam int PEAK_FLOOR = 8;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[src/rtea_ifs.sv]
// rtea_ifs: valid/ready channel interfaces for samples in, results out and
// configuration writes. Depends on rtea_pkg for the configuration widths.
interface rtea_in_if #(parameter int SB = 24);
  logic          valid;
  logic          ready;
  logic          func;
  logic          first;
  logic [SB-1:0] sample_in;

  modport source (output valid, output func, output first, output sample_in, input ready);
  modport sink   (input valid, input func, input first, input sample_in, output ready);
endinterface

interface rtea_out_if #(parameter int SB = 24);
  logic          valid;
  logic          ready;
  logic [SB-1:0] sample_out;
  logic          clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface rtea_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtea_pkg::CFG_IDX_W-1:0]  index;
  logic [rtea_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/rtea_front.sv]
// rtea_front: accepts samples and config writes, keeps index, peak and envelope,
// and queues apply-pass work for the back end. Depends on rtea_pkg, rtea_ifs.
module rtea_front #(
  parameter int MAX_LEN = 65536,
  parameter int SB      = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  rtea_in_if.sink                              din,
  rtea_cfg_if.sink                             cfg,
  input  rtea_pkg::qstat_t                     qstat,
  output logic                                 push,
  output logic [2*SB+rtea_pkg::ENV_W:0]        push_data
);

  localparam int IDX_W = $clog2(MAX_LEN + 1);
  localparam int CMP_W = (IDX_W > rtea_pkg::XOVER_W) ? IDX_W : rtea_pkg::XOVER_W;
  localparam int EP_W  = rtea_pkg::ENV_W + rtea_pkg::DECAY_W;

  logic [rtea_pkg::XOVER_W-1:0] crossover;
  logic [rtea_pkg::DECAY_W-1:0] decay;
  logic [IDX_W-1:0]             sample_index;
  logic [SB-1:0]                peak_level;
  logic [rtea_pkg::ENV_W-1:0]   envelope;

  logic                         accept;
  logic [IDX_W-1:0]             idx_base;
  logic [SB-1:0]                peak_base;
  logic [rtea_pkg::ENV_W-1:0]   env_base;
  logic                         tail_zone;
  logic [SB-1:0]                abs_s;
  logic [EP_W-1:0]              env_prod;
  logic                         add_tail;

  assign din.ready = !qstat.full;
  assign cfg.ready = 1'b1;
  assign accept    = din.valid && din.ready;

  // a first mark restarts the pass before the sample is used
  assign idx_base  = din.first ? '0 : sample_index;
  assign peak_base = (din.first && !din.func) ? '0 : peak_level;
  assign env_base  = (din.first && din.func) ? rtea_pkg::ENV_ONE : envelope;
  assign tail_zone = CMP_W'(idx_base) >= CMP_W'(crossover);

  // most negative sample maps to 2^(SB-1), exact as unsigned
  assign abs_s    = din.sample_in[SB-1] ? (~din.sample_in + SB'(1)) : din.sample_in;
  assign env_prod = EP_W'(env_base) * EP_W'(decay);
  assign add_tail = tail_zone && (peak_level > SB'(rtea_pkg::PEAK_FLOOR));

  assign push      = accept && din.func;
  assign push_data = {din.sample_in, add_tail, peak_level, env_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      crossover <= '0;
      decay     <= '1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        rtea_pkg::CFG_XOVER: crossover <= rtea_pkg::XOVER_W'(cfg.data);
        rtea_pkg::CFG_DECAY: decay     <= rtea_pkg::DECAY_W'(cfg.data);
        default:             decay     <= decay;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      peak_level   <= '0;
      envelope     <= rtea_pkg::ENV_ONE;
    end else if (accept) begin
      // index saturates at the maximum stream length
      sample_index <= (idx_base < IDX_W'(MAX_LEN)) ? idx_base + IDX_W'(1) : idx_base;
      if (!din.func) begin
        peak_level <= (tail_zone && (abs_s > peak_base)) ? abs_s : peak_base;
      end else begin
        envelope <= tail_zone ? env_prod[EP_W-1:rtea_pkg::FRAC_W] : env_base;
      end
    end
  end

endmodule

[src/rtea_queue.sv]
// rtea_queue: short register queue between front and back end.
// Depends on rtea_pkg for the depth and the status struct.
module rtea_queue #(
  parameter int W = 74
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [W-1:0]     push_data,
  input  logic             pop,
  output logic [W-1:0]     head,
  output rtea_pkg::qstat_t qstat
);

  localparam int DEPTH = rtea_pkg::QDEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = count == CNT_W'(DEPTH);
  assign qstat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[src/rtea_back.sv]
// rtea_back: two-stage tail datapath, peak times envelope then times gain,
// add and saturate into the output register. Depends on rtea_pkg, rtea_ifs.
module rtea_back #(
  parameter int SB = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rtea_pkg::qstat_t               qstat,
  input  logic [2*SB+rtea_pkg::ENV_W:0]  head,
  output logic                           pop,
  rtea_out_if.source                     dout
);

  localparam int ENV_W = rtea_pkg::ENV_W;
  localparam int FR    = rtea_pkg::FRAC_W;
  localparam int P1_W  = SB + ENV_W;
  localparam int P2_W  = SB + rtea_pkg::GAIN_W + 1;
  localparam int S_W   = SB + 2;

  logic [SB-1:0]    q_sample;
  logic             q_add;
  logic [SB-1:0]    q_peak;
  logic [ENV_W-1:0] q_env;
  logic [P1_W-1:0]  prod1;

  logic             mid_vld;
  logic [SB-1:0]    mid_sample;
  logic             mid_add;
  logic [SB-1:0]    mid_scaled;

  logic [P2_W-1:0]  prod2;
  logic [SB-1:0]    tail;
  logic [S_W-1:0]   sum;
  logic             ovf;
  logic [SB-1:0]    res;
  logic             res_clip;

  logic             out_vld;
  logic [SB-1:0]    out_sample;
  logic             out_clip;
  logic             out_adv;
  logic             mid_adv;

  assign {q_sample, q_add, q_peak, q_env} = head;

  // round half up: scaled = (peak * env + half) >> 24
  assign prod1 = P1_W'(q_peak) * P1_W'(q_env) + P1_W'(rtea_pkg::ROUND_HALF);

  assign prod2 = P2_W'(mid_scaled) * P2_W'(rtea_pkg::TAIL_GAIN)
               + P2_W'(rtea_pkg::ROUND_HALF);
  assign tail  = prod2[FR+SB-1:FR];
  assign sum   = {{2{mid_sample[SB-1]}}, mid_sample} + {2'b00, tail};
  // overflow when the top three bits disagree
  assign ovf   = !((sum[S_W-1:SB-1] == 3'b000) || (sum[S_W-1:SB-1] == 3'b111));

  always_comb begin
    res      = mid_sample;
    res_clip = 1'b0;
    if (mid_add) begin
      res = sum[SB-1:0];
      if (ovf) begin
        res_clip = 1'b1;
        res      = sum[S_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end
    end
  end

  assign out_adv = !out_vld || dout.ready;
  assign mid_adv = !mid_vld || out_adv;
  assign pop     = !qstat.empty && mid_adv;

  assign dout.valid      = out_vld;
  assign dout.sample_out = out_sample;
  assign dout.clipped    = out_clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (mid_adv) mid_vld <= pop;
      if (out_adv) out_vld <= mid_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mid_sample <= q_sample;
      mid_add    <= q_add;
      mid_scaled <= prod1[FR+SB-1:FR];
    end
    if (out_adv && mid_vld) begin
      out_sample <= res;
      out_clip   <= res_clip;
    end
  end

endmodule

[src/reverb_tail_envelope_add_top.sv]
// Reverb tail envelope adder. The front end takes one sample beat per cycle while the
// four-entry queue has room; a measure-pass beat only updates index and peak and gives
// no result, an apply-pass beat gives one result via queue, peak-times-envelope stage
// and gain-add-saturate output register. Sustained rate is one sample per cycle unless
// output stalls, set by the single 25x24 envelope multiply in the front end, which
// must finish before the next apply sample. Write configuration only while no result
// is outstanding. Depends on rtea_pkg, rtea_ifs, rtea_front, rtea_queue, rtea_back.
module reverb_tail_envelope_add_top #(
  parameter int MAX_LEN     = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  rtea_in_if.sink    din,
  rtea_out_if.source dout,
  rtea_cfg_if.sink   cfg
);

  localparam int QW = 2 * SAMPLE_BITS + rtea_pkg::ENV_W + 1;

  rtea_pkg::qstat_t qstat;
  logic             push;
  logic [QW-1:0]    push_data;
  logic             pop;
  logic [QW-1:0]    head;

  rtea_front #(.MAX_LEN(MAX_LEN), .SB(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .din       (din),
    .cfg       (cfg),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  rtea_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  rtea_back #(.SB(SAMPLE_BITS)) u_back (
    .clk   (clk),
    .rst   (rst),
    .qstat (qstat),
    .head  (head),
    .pop   (pop),
    .dout  (dout)
  );

endmodule

[src/rtea_checker.sv]
// rtea_checker: port-level assertions for the reverb tail envelope adder,
// bound to the top level. Depends on reverb_tail_envelope_add_top and rtea_ifs.
module rtea_checker #(
  parameter int SB = 24
) (
  input logic          clk,
  input logic          rst,
  input logic          din_valid,
  input logic          din_ready,
  input logic          din_func,
  input logic          dout_valid,
  input logic          dout_ready,
  input logic [SB-1:0] dout_sample,
  input logic          dout_clipped
);

  logic [3:0] pending;
  logic       in_apply;
  logic       out_fire;

  assign in_apply = din_valid && din_ready && din_func;
  assign out_fire = dout_valid && dout_ready;

  // apply beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {3'b000, in_apply} - {3'b000, out_fire};
    end
  end

  a_idle_after_reset: assert property (@(posedge clk) rst |=> !dout_valid)
    else $error("result valid straight after reset");

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    dout_valid |-> pending != 4'd0)
    else $error("result without an accepted apply beat");

  a_bounded_flight: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd6)
    else $error("more apply beats in flight than queue and stages hold");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    (dout_valid && dout_clipped) |->
      (dout_sample == {1'b0, {(SB-1){1'b1}}}) || (dout_sample == {1'b1, {(SB-1){1'b0}}}))
    else $error("clipped result not at a rail");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (dout_valid && !dout_ready) |=> dout_valid && $stable(dout_sample) && $stable(dout_clipped))
    else $error("stalled result changed");

endmodule

bind reverb_tail_envelope_add_top rtea_checker #(.SB(SAMPLE_BITS)) u_checker (
  .clk          (clk),
  .rst          (rst),
  .din_valid    (din.valid),
  .din_ready    (din.ready),
  .din_func     (din.func),
  .dout_valid   (dout.valid),
  .dout_ready   (dout.ready),
  .dout_sample  (dout.sample_out),
  .dout_clipped (dout.clipped)
);
